@@ sv/abb_pkg.sv @@
// Shared types and constants for the branch-and-bound assignment solver.
// Has no dependencies; every other file refers to it by scoped names.
package abb_pkg;

    // Field widths fixed by the block's interface.
    localparam int FIELD_IDX_W = 3;
    localparam int COST_W      = 16;
    localparam int TOTAL_W     = 24;
    localparam int JOB_COUNT_W = 4;

    // Best total that every search starts from.
    localparam logic [TOTAL_W-1:0] INIT_BEST = 24'd9999999;

    // Input word command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    // Sequencer states of the search engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ENTER,
        S_LOOP,
        S_SW_RD,
        S_SW_WA,
        S_SW_WB,
        S_COST_RD,
        S_COST_ADD,
        S_POST,
        S_RET,
        S_COPY,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // One result word as handed from the search engine to the output register.
    typedef struct packed {
        logic [FIELD_IDX_W-1:0] person;
        logic [FIELD_IDX_W-1:0] job;
        logic [TOTAL_W-1:0]     total_cost;
        logic                   last;
    } t_result;

endpackage

@@ sv/abb_cost_store.sv @@
// Cost matrix store: one write port for cost words, one registered read port.
// Depends on abb_pkg for field widths.
module abb_cost_store #(
    parameter int MAX_SIZE = 8
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [abb_pkg::FIELD_IDX_W-1:0]     i_wr_job,
    input  logic [abb_pkg::FIELD_IDX_W-1:0]     i_wr_person,
    input  logic [abb_pkg::COST_W-1:0]          i_wr_cost,
    input  logic                                i_rd_en,
    input  logic [$clog2(MAX_SIZE)-1:0]         i_rd_job,
    input  logic [$clog2(MAX_SIZE)-1:0]         i_rd_person,
    output logic [abb_pkg::COST_W-1:0]          o_rd_cost
);

    localparam int CA_W = $clog2(MAX_SIZE * MAX_SIZE);

    logic [abb_pkg::COST_W-1:0] cost_mem [MAX_SIZE*MAX_SIZE];
    logic [abb_pkg::COST_W-1:0] r_rd_cost;
    logic                       wr_in_range;
    logic [CA_W-1:0]            wr_addr;
    logic [CA_W-1:0]            rd_addr;

    // Writes that name a row or column beyond the matrix are dropped.
    assign wr_in_range = (32'(i_wr_job) < MAX_SIZE) && (32'(i_wr_person) < MAX_SIZE);
    assign wr_addr     = CA_W'(32'(i_wr_job) * MAX_SIZE + 32'(i_wr_person));
    assign rd_addr     = CA_W'(32'(i_rd_job) * MAX_SIZE + 32'(i_rd_person));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            cost_mem[wr_addr] <= i_wr_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_cost <= cost_mem[rd_addr];
        end
    end

    assign o_rd_cost = r_rd_cost;

endmodule

@@ sv/abb_search.sv @@
// Depth-first search engine with an explicit level stack and a permutation memory.
// Depends on abb_pkg; reads costs through the cost store's registered port.
module abb_search #(
    parameter int MAX_SIZE = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(MAX_SIZE+1)-1:0]         i_n,
    output logic                                  o_busy,
    output logic                                  o_cost_re,
    output logic [$clog2(MAX_SIZE)-1:0]           o_cost_job,
    output logic [$clog2(MAX_SIZE)-1:0]           o_cost_person,
    input  logic [abb_pkg::COST_W-1:0]            i_cost,
    input  logic                                  i_res_ready,
    output logic                                  o_res_load,
    output abb_pkg::t_result                      o_res
);

    localparam int IDX_W = $clog2(MAX_SIZE);
    localparam int LVL_W = $clog2(MAX_SIZE + 1);
    localparam int PA_W  = $clog2(2 * MAX_SIZE);
    localparam int TW    = abb_pkg::TOTAL_W;

    // Permutation memory: current permutation in the lower half, best one in the upper.
    logic [IDX_W-1:0] perm_mem [2*MAX_SIZE];
    logic [IDX_W-1:0] r_ra;
    logic [IDX_W-1:0] r_rb;
    logic             pm_we;
    logic [PA_W-1:0]  pm_waddr;
    logic [IDX_W-1:0] pm_wdata;
    logic             pm_re;
    logic [PA_W-1:0]  pm_ra_addr;
    logic [PA_W-1:0]  pm_rb_addr;

    // Per-level stacks, each read only at the current level.
    logic [LVL_W-1:0] r_k    [MAX_SIZE];
    logic [TW-1:0]    r_psum [MAX_SIZE];
    logic             k_we;
    logic [LVL_W-1:0] k_wdata;
    logic             psum_we;

    abb_pkg::t_state  r_state, n_state;
    logic [LVL_W-1:0] r_n, n_n;
    logic [LVL_W-1:0] r_level, n_level;
    logic [LVL_W-1:0] r_cnt, n_cnt;
    logic [TW-1:0]    r_partial, n_partial;
    logic [TW-1:0]    r_best, n_best;
    logic             r_undo, n_undo;
    logic [IDX_W-1:0] r_jb, n_jb;
    logic [IDX_W-1:0] r_hold, n_hold;

    logic [IDX_W-1:0] lvl_idx;
    logic [LVL_W-1:0] k_cur;
    logic [TW-1:0]    sum;

    assign lvl_idx = r_level[IDX_W-1:0];
    assign k_cur   = r_k[lvl_idx];
    assign sum     = r_partial + TW'(i_cost);

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_level    = r_level;
        n_cnt      = r_cnt;
        n_partial  = r_partial;
        n_best     = r_best;
        n_undo     = r_undo;
        n_jb       = r_jb;
        n_hold     = r_hold;
        pm_we      = 1'b0;
        pm_waddr   = PA_W'(lvl_idx);
        pm_wdata   = r_rb;
        pm_re      = 1'b0;
        pm_ra_addr = PA_W'(lvl_idx);
        pm_rb_addr = PA_W'(k_cur[IDX_W-1:0]);
        k_we       = 1'b0;
        k_wdata    = r_level;
        psum_we    = 1'b0;
        o_cost_re  = 1'b0;
        o_res_load = 1'b0;
        case (r_state)
            abb_pkg::S_IDLE: begin
                if (i_start) begin
                    n_n       = i_n;
                    n_cnt     = '0;
                    n_level   = '0;
                    n_partial = '0;
                    n_best    = abb_pkg::INIT_BEST;
                    n_state   = abb_pkg::S_INIT;
                end
            end
            abb_pkg::S_INIT: begin
                // Identity permutation, one entry a cycle.
                pm_we    = 1'b1;
                pm_waddr = PA_W'(r_cnt);
                pm_wdata = IDX_W'(r_cnt);
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt + 1'b1 == r_n) begin
                    n_state = abb_pkg::S_ENTER;
                end
            end
            abb_pkg::S_ENTER: begin
                if (r_level == r_n) begin
                    // Complete permutation: it is always better than the best so far.
                    n_best  = r_partial;
                    n_cnt   = '0;
                    n_state = abb_pkg::S_COPY;
                end else begin
                    k_we    = 1'b1;
                    k_wdata = r_level;
                    n_state = abb_pkg::S_LOOP;
                end
            end
            abb_pkg::S_LOOP: begin
                if (k_cur < r_n) begin
                    n_undo  = 1'b0;
                    n_state = abb_pkg::S_SW_RD;
                end else begin
                    n_state = abb_pkg::S_RET;
                end
            end
            abb_pkg::S_SW_RD: begin
                pm_re   = 1'b1;
                n_state = abb_pkg::S_SW_WA;
            end
            abb_pkg::S_SW_WA: begin
                pm_we    = 1'b1;
                pm_waddr = PA_W'(lvl_idx);
                pm_wdata = r_rb;
                n_hold   = r_ra;
                n_jb     = r_rb;
                n_state  = abb_pkg::S_SW_WB;
            end
            abb_pkg::S_SW_WB: begin
                pm_we    = 1'b1;
                pm_waddr = PA_W'(k_cur[IDX_W-1:0]);
                pm_wdata = r_hold;
                if (r_undo) begin
                    k_we    = 1'b1;
                    k_wdata = k_cur + 1'b1;
                    n_state = abb_pkg::S_LOOP;
                end else begin
                    n_state = abb_pkg::S_COST_RD;
                end
            end
            abb_pkg::S_COST_RD: begin
                o_cost_re = 1'b1;
                n_state   = abb_pkg::S_COST_ADD;
            end
            abb_pkg::S_COST_ADD: begin
                psum_we   = 1'b1;
                n_partial = sum;
                if (sum < r_best) begin
                    n_level = r_level + 1'b1;
                    n_state = abb_pkg::S_ENTER;
                end else begin
                    n_state = abb_pkg::S_POST;
                end
            end
            abb_pkg::S_POST: begin
                n_partial = r_psum[lvl_idx];
                n_undo    = 1'b1;
                n_state   = abb_pkg::S_SW_RD;
            end
            abb_pkg::S_RET: begin
                if (r_level == '0) begin
                    n_cnt   = '0;
                    n_state = abb_pkg::S_OUT_RD;
                end else begin
                    n_level = r_level - 1'b1;
                    n_state = abb_pkg::S_POST;
                end
            end
            abb_pkg::S_COPY: begin
                // Read current entry cnt while writing entry cnt-1 into the best half.
                pm_ra_addr = PA_W'(r_cnt[IDX_W-1:0]);
                pm_re      = (r_cnt < r_n);
                pm_we      = (r_cnt != '0);
                pm_waddr   = PA_W'(MAX_SIZE) + PA_W'(r_cnt - 1'b1);
                pm_wdata   = r_ra;
                if (r_cnt == r_n) begin
                    n_state = abb_pkg::S_RET;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            abb_pkg::S_OUT_RD: begin
                pm_re      = 1'b1;
                pm_ra_addr = PA_W'(MAX_SIZE) + PA_W'(r_cnt[IDX_W-1:0]);
                n_state    = abb_pkg::S_OUT_LD;
            end
            abb_pkg::S_OUT_LD: begin
                if (i_res_ready) begin
                    o_res_load = 1'b1;
                    if (r_cnt + 1'b1 == r_n) begin
                        n_state = abb_pkg::S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = abb_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = abb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abb_pkg::S_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_cnt     <= n_cnt;
        r_partial <= n_partial;
        r_best    <= n_best;
        r_undo    <= n_undo;
        r_jb      <= n_jb;
        r_hold    <= n_hold;
        if (k_we) begin
            r_k[lvl_idx] <= k_wdata;
        end
        if (psum_we) begin
            r_psum[lvl_idx] <= r_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            perm_mem[pm_waddr] <= pm_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pm_re) begin
            r_ra <= perm_mem[pm_ra_addr];
            r_rb <= perm_mem[pm_rb_addr];
        end
    end

    assign o_busy        = (r_state != abb_pkg::S_IDLE);
    assign o_cost_job    = r_jb;
    assign o_cost_person = lvl_idx;

    assign o_res.person     = abb_pkg::FIELD_IDX_W'(r_cnt);
    assign o_res.job        = abb_pkg::FIELD_IDX_W'(r_ra);
    assign o_res.total_cost = r_best;
    assign o_res.last       = (r_cnt + 1'b1 == r_n);

endmodule

@@ sv/assignment_branch_and_bound.sv @@
// Top level of the branch-and-bound assignment solver.
// Depends on abb_pkg, abb_cost_store and abb_search.
//
// Channel     Direction  Handshake                 Word
// input       in         i_valid / o_stall         command, job_index, person_index, cost_value
// result      out        o_valid / i_stall         person, job, total_cost, last
// config      in         i_cfg_valid / o_cfg_ready job_count
//
// Cost writes can stream one a cycle while the block is idle.
// A solve runs for as long as the pruned search needs: each tried branch costs a swap in
// the permutation memory, a cost read and, on return, a swap back and the index update;
// every improved leaf adds a copy of the permutation into the best half. Results then
// leave one word at a time as the output register takes them. Reset clears the sequencer and
// the output valid and sets the job count to eight; the cost matrix keeps its contents.
// Input stall is high for the whole solve; a stalled result holds in the output register
// while the block takes new cost writes.
module assignment_branch_and_bound #(
    parameter int MAX_SIZE = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [abb_pkg::FIELD_IDX_W-1:0]     i_job_index,
    input  logic [abb_pkg::FIELD_IDX_W-1:0]     i_person_index,
    input  logic [abb_pkg::COST_W-1:0]          i_cost_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [abb_pkg::FIELD_IDX_W-1:0]     o_person,
    output logic [abb_pkg::FIELD_IDX_W-1:0]     o_job,
    output logic [abb_pkg::TOTAL_W-1:0]         o_total_cost,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [abb_pkg::JOB_COUNT_W-1:0]     i_cfg_job_count
);

    localparam int IDX_W = $clog2(MAX_SIZE);
    localparam int LVL_W = $clog2(MAX_SIZE + 1);

    logic [abb_pkg::JOB_COUNT_W-1:0] r_job_count;
    logic                            r_out_valid;
    abb_pkg::t_result                r_out;

    logic                            busy;
    logic                            in_accept;
    logic                            start;
    logic                            wr_en;
    logic [LVL_W-1:0]                n_size;
    logic                            cost_re;
    logic [IDX_W-1:0]                cost_job;
    logic [IDX_W-1:0]                cost_person;
    logic [abb_pkg::COST_W-1:0]      cost_rd;
    logic                            res_ready;
    logic                            res_load;
    abb_pkg::t_result                res;

    // The register port is always open; the user must write it only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_count <= abb_pkg::JOB_COUNT_W'(8);
        end else if (i_cfg_valid) begin
            r_job_count <= i_cfg_job_count;
        end
    end

    // The job count is clamped into one to the matrix size when a solve picks it up.
    always_comb begin
        if (r_job_count == '0) begin
            n_size = LVL_W'(1);
        end else if (32'(r_job_count) > MAX_SIZE) begin
            n_size = LVL_W'(MAX_SIZE);
        end else begin
            n_size = LVL_W'(r_job_count);
        end
    end

    // Input words are taken only while the search engine is idle.
    assign o_stall   = busy;
    assign in_accept = i_valid && !busy;
    assign start     = in_accept && (i_command == abb_pkg::CMD_SOLVE);
    assign wr_en     = in_accept && (i_command == abb_pkg::CMD_WRITE);

    abb_cost_store #(
        .MAX_SIZE (MAX_SIZE)
    ) u_cost (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_job    (i_job_index),
        .i_wr_person (i_person_index),
        .i_wr_cost   (i_cost_value),
        .i_rd_en     (cost_re),
        .i_rd_job    (cost_job),
        .i_rd_person (cost_person),
        .o_rd_cost   (cost_rd)
    );

    abb_search #(
        .MAX_SIZE (MAX_SIZE)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_n           (n_size),
        .o_busy        (busy),
        .o_cost_re     (cost_re),
        .o_cost_job    (cost_job),
        .o_cost_person (cost_person),
        .i_cost        (cost_rd),
        .i_res_ready   (res_ready),
        .o_res_load    (res_load),
        .o_res         (res)
    );

    // Output register: it takes a new word when empty or when its word leaves this cycle.
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_person     = r_out.person;
    assign o_job        = r_out.job;
    assign o_total_cost = r_out.total_cost;
    assign o_last       = r_out.last;

endmodule
